[rtl/resp_request_stream_parser_top_defines.svh]
// Assertion macros shared by the request stream parser modules.
`ifndef RESP_REQUEST_STREAM_PARSER_TOP_DEFINES_SVH
`define RESP_REQUEST_STREAM_PARSER_TOP_DEFINES_SVH

// Clocked check, off while reset is held.
`define RRSP_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rrsp check failed");

// Clocked check that also holds during reset.
`define RRSP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("rrsp check failed");

`endif

[rtl/rrsp_pkg.sv]
// Types, codes and helpers for the request stream parser.
package rrsp_pkg;

  localparam int RRSP_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [1:0] EV_BYTE = 2'd0;
  localparam logic [1:0] EV_AEND = 2'd1;
  localparam logic [1:0] EV_CEND = 2'd2;
  localparam logic [1:0] EV_ERR  = 2'd3;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_INLINE_LEN = 3'd1;
  localparam logic [2:0] ERR_BAD_DIGIT  = 3'd2;
  localparam logic [2:0] ERR_OVER_LIMIT = 3'd3;
  localparam logic [2:0] ERR_NO_LF      = 3'd4;
  localparam logic [2:0] ERR_NO_DOLLAR  = 3'd5;
  localparam logic [2:0] ERR_ZERO_COUNT = 3'd6;
  localparam logic [2:0] ERR_NO_CRLF    = 3'd7;

  localparam logic [1:0] CFG_INLINE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_COUNT_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd2;

  localparam logic [15:0] INLINE_LIMIT_RST = 16'd4096;
  localparam logic [19:0] COUNT_LIMIT_RST  = 20'd1024;
  localparam logic [24:0] LENGTH_LIMIT_RST = 25'd4096;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_INLINE,
    PH_COUNT,
    PH_COUNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF
  } phase_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  byte_value;
    logic [2:0]  error_kind;
    logic [19:0] argument_total;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]       count;
    result_t [1:0]    res;
  } emit_t;

  function automatic result_t mk_res(logic [1:0] kind, logic [7:0] value,
                                     logic [2:0] err, logic [19:0] total);
    result_t r;
    r.event_kind     = kind;
    r.byte_value     = value;
    r.error_kind     = err;
    r.argument_total = total;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

endpackage

[rtl/rrsp_core.sv]
// Parser state and per-byte decode producing up to two result items.
`include "resp_request_stream_parser_top_defines.svh"

module rrsp_core
  import rrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  byte_in,
  input  logic [15:0] inline_lim,
  input  logic [19:0] count_lim,
  input  logic [24:0] len_lim,
  output emit_t       emit
);

  phase_t      phase_r, phase_nxt;
  logic [24:0] acc_r, acc_nxt;
  logic [19:0] remain_r, remain_nxt;
  logic [24:0] bulk_r, bulk_nxt;
  logic [15:0] inl_cnt_r, inl_cnt_nxt;
  logic        crp_r, crp_nxt;
  logic        tok_r, tok_nxt;
  logic [19:0] emitted_r, emitted_nxt;

  logic          is_digit;
  logic [28:0]   val;
  logic [28:0]   lim;
  logic          do_inline;
  logic          clear;
  logic          tok_v;
  logic [19:0]   emitted_v;
  logic [19:0]   remain_v;
  logic [24:0]   bulk_v;
  logic [1:0]    n;
  result_t [1:0] res;

  assign is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
  assign val = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {25'd0, byte_in[3:0]};
  assign lim = (phase_r == PH_COUNT) ? {9'd0, count_lim} : {4'd0, len_lim};

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    remain_nxt  = remain_r;
    bulk_nxt    = bulk_r;
    inl_cnt_nxt = inl_cnt_r;
    crp_nxt     = crp_r;
    tok_nxt     = tok_r;
    emitted_nxt = emitted_r;
    do_inline   = 1'b0;
    clear       = 1'b0;
    tok_v       = tok_r;
    emitted_v   = emitted_r;
    remain_v    = remain_r;
    bulk_v      = bulk_r;
    n           = 2'd0;
    res         = '0;

    unique case (phase_r)
      PH_IDLE: begin
        if (byte_in == CH_STAR) begin
          phase_nxt = PH_COUNT;
          acc_nxt   = '0;
        end else begin
          do_inline = 1'b1;
        end
      end
      PH_INLINE: do_inline = 1'b1;
      PH_COUNT, PH_LEN: begin
        if (byte_in == CH_CR) begin
          phase_nxt = (phase_r == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else if (!is_digit) begin
          res[0] = mk_res(EV_ERR, 8'd0, ERR_BAD_DIGIT, 20'd0);
          n      = 2'd1;
          clear  = 1'b1;
        end else if (val > lim) begin
          res[0] = mk_res(EV_ERR, 8'd0, ERR_OVER_LIMIT, 20'd0);
          n      = 2'd1;
          clear  = 1'b1;
        end else begin
          acc_nxt = val[24:0];
        end
      end
      PH_COUNT_LF: begin
        if (byte_in != CH_LF) begin
          res[0] = mk_res(EV_ERR, 8'd0, ERR_NO_LF, 20'd0);
          n      = 2'd1;
          clear  = 1'b1;
        end else if (acc_r == '0) begin
          res[0] = mk_res(EV_ERR, 8'd0, ERR_ZERO_COUNT, 20'd0);
          n      = 2'd1;
          clear  = 1'b1;
        end else begin
          remain_nxt  = acc_r[19:0];
          emitted_nxt = '0;
          acc_nxt     = '0;
          phase_nxt   = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (byte_in != CH_DOLLAR) begin
          res[0] = mk_res(EV_ERR, 8'd0, ERR_NO_DOLLAR, 20'd0);
          n      = 2'd1;
          clear  = 1'b1;
        end else begin
          acc_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN_LF: begin
        if (byte_in != CH_LF) begin
          res[0] = mk_res(EV_ERR, 8'd0, ERR_NO_LF, 20'd0);
          n      = 2'd1;
          clear  = 1'b1;
        end else begin
          bulk_nxt  = acc_r;
          acc_nxt   = '0;
          phase_nxt = (acc_r == '0) ? PH_DATA_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        res[0]   = mk_res(EV_BYTE, byte_in, ERR_NONE, 20'd0);
        n        = 2'd1;
        bulk_v   = bulk_r - 25'd1;
        bulk_nxt = bulk_v;
        if (bulk_v == '0) begin
          phase_nxt = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (byte_in != CH_CR) begin
          res[0] = mk_res(EV_ERR, 8'd0, ERR_NO_CRLF, 20'd0);
          n      = 2'd1;
          clear  = 1'b1;
        end else begin
          phase_nxt = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (byte_in != CH_LF) begin
          res[0] = mk_res(EV_ERR, 8'd0, ERR_NO_CRLF, 20'd0);
          n      = 2'd1;
          clear  = 1'b1;
        end else begin
          emitted_v   = emitted_r + 20'd1;
          emitted_nxt = emitted_v;
          res[0]      = mk_res(EV_AEND, 8'd0, ERR_NONE, 20'd0);
          n           = 2'd1;
          remain_v    = remain_r - 20'd1;
          remain_nxt  = remain_v;
          if (remain_v == '0) begin
            res[1] = mk_res(EV_CEND, 8'd0, ERR_NONE, emitted_v);
            n      = 2'd2;
            clear  = 1'b1;
          end else begin
            phase_nxt = PH_DOLLAR;
          end
        end
      end
      default: clear = 1'b1;
    endcase

    if (do_inline) begin
      phase_nxt = PH_INLINE;
      if (byte_in == CH_LF) begin
        if (tok_r) begin
          emitted_v = emitted_r + 20'd1;
          res[0]    = mk_res(EV_AEND, 8'd0, ERR_NONE, 20'd0);
          n         = 2'd1;
        end
        res[n[0]] = mk_res(EV_CEND, 8'd0, ERR_NONE, emitted_v);
        n         = n + 2'd1;
        clear     = 1'b1;
      end else if (inl_cnt_r >= inline_lim) begin
        res[0] = mk_res(EV_ERR, 8'd0, ERR_INLINE_LEN, 20'd0);
        n      = 2'd1;
        clear  = 1'b1;
      end else begin
        inl_cnt_nxt = inl_cnt_r + 16'd1;
        if (crp_r) begin
          crp_nxt = 1'b0;
          tok_v   = 1'b1;
          res[0]  = mk_res(EV_BYTE, CH_CR, ERR_NONE, 20'd0);
          n       = 2'd1;
        end
        if (byte_in == CH_CR) begin
          crp_nxt = 1'b1;
        end else if (byte_in == CH_SPACE || byte_in == CH_TAB) begin
          if (tok_v) begin
            tok_v     = 1'b0;
            emitted_v = emitted_r + 20'd1;
            res[n[0]] = mk_res(EV_AEND, 8'd0, ERR_NONE, 20'd0);
            n         = n + 2'd1;
          end
        end else begin
          tok_v     = 1'b1;
          res[n[0]] = mk_res(EV_BYTE, byte_in, ERR_NONE, 20'd0);
          n         = n + 2'd1;
        end
        tok_nxt     = tok_v;
        emitted_nxt = emitted_v;
      end
    end

    if (clear) begin
      phase_nxt   = PH_IDLE;
      acc_nxt     = '0;
      remain_nxt  = '0;
      bulk_nxt    = '0;
      inl_cnt_nxt = '0;
      crp_nxt     = 1'b0;
      tok_nxt     = 1'b0;
      emitted_nxt = '0;
    end

    if (n == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end

    emit.count = n;
    emit.res   = res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      acc_r     <= '0;
      remain_r  <= '0;
      bulk_r    <= '0;
      inl_cnt_r <= '0;
      crp_r     <= 1'b0;
      tok_r     <= 1'b0;
      emitted_r <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      remain_r  <= remain_nxt;
      bulk_r    <= bulk_nxt;
      inl_cnt_r <= inl_cnt_nxt;
      crp_r     <= crp_nxt;
      tok_r     <= tok_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  `RRSP_ASSERT(a_err_alone, (emit.count != 2'd0 && emit.res[0].event_kind == EV_ERR) |-> (emit.count == 2'd1))
  `RRSP_ASSERT(a_last_pair, (emit.count == 2'd2) |-> (!emit.res[0].last_of_run && emit.res[1].last_of_run))
  `RRSP_ASSERT(a_err_resync, (fire && emit.count == 2'd1 && emit.res[0].event_kind == EV_ERR) |=> (phase_r == PH_IDLE && !tok_r && emitted_r == '0))

endmodule

[rtl/rrsp_fifo.sv]
// Result queue: takes up to two items per cycle, hands out one from its head.
`include "resp_request_stream_parser_top_defines.svh"

module rrsp_fifo
  import rrsp_pkg::*;
#(
  parameter int Depth = RRSP_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_cnt,
  input  result_t [1:0] push_data,
  input  logic          pop,
  output logic          room,
  output logic          out_valid,
  output result_t       out_data
);

  localparam int CW = $clog2(Depth + 1);

  result_t        q_r   [Depth];
  result_t        q_nxt [Depth];
  result_t        q_sh  [Depth];
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  base;

  for (genvar g = 0; g < Depth; g++) begin : g_shift
    if (g == Depth - 1) begin : g_top
      assign q_sh[g] = q_r[g];
    end else begin : g_mid
      assign q_sh[g] = q_r[g+1];
    end
  end

  assign base      = count_r - CW'(pop);
  assign count_nxt = base + CW'(push_cnt);
  assign room      = count_r <= CW'(Depth - 2);
  assign out_valid = count_r != '0;
  assign out_data  = q_r[0];

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (CW'(i) < base) begin
        q_nxt[i] = pop ? q_sh[i] : q_r[i];
      end else if (CW'(i) == base && push_cnt != 2'd0) begin
        q_nxt[i] = push_data[0];
      end else if (CW'(i) == base + CW'(1) && push_cnt == 2'd2) begin
        q_nxt[i] = push_data[1];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  `RRSP_ASSERT(a_cnt_max, count_r <= CW'(Depth))
  `RRSP_ASSERT(a_no_ovf, (push_cnt != 2'd0) |-> (count_r <= CW'(Depth - 2)))
  `RRSP_ASSERT(a_cnt_pop, (pop && push_cnt == 2'd0) |=> (count_r == $past(count_r) - CW'(1)))

endmodule

[rtl/resp_request_stream_parser_top.sv]
// Request stream parser: bulk and inline command byte parser, top level.
// Takes one request byte per item and emits parse events (argument byte, argument
// end, command end, protocol error) as result items. Each accepted byte waits in an
// input register until the result queue has room, is decoded combinationally against
// the parser state, and its zero, one or two results then enter a small result queue,
// from whose head they reach the output. A byte can be taken every cycle as long as
// the output drains; the output port moves one result per cycle, so a byte that yields
// two results (argument end with command end, or a held CR with the next byte) needs
// an output transfer for each. The input stalls only when the result queue has fewer
// than two free entries. Limits are to be written through the cfg port only while the
// parser is idle; the block itself does not enforce this. After a protocol error the
// next byte starts a new command. No clearing pass after reset.
module resp_request_stream_parser_top
  import rrsp_pkg::*;
#(
  parameter int FifoDepth = RRSP_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_byte_value,
  output logic [2:0]  out_error_kind,
  output logic [19:0] out_argument_total,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  logic [15:0] inline_lim_r;
  logic [19:0] count_lim_r;
  logic [24:0] len_lim_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        room;
  logic        fire;
  logic        pop;
  emit_t       emit;
  result_t     head;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid_r && room;
  assign in_ready  = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inline_lim_r <= INLINE_LIMIT_RST;
      count_lim_r  <= COUNT_LIMIT_RST;
      len_lim_r    <= LENGTH_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INLINE_LIMIT: inline_lim_r <= cfg_data[15:0];
        CFG_COUNT_LIMIT:  count_lim_r  <= cfg_data[19:0];
        CFG_LENGTH_LIMIT: len_lim_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte_in;
    end
  end

  rrsp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .byte_in    (s1_byte_r),
    .inline_lim (inline_lim_r),
    .count_lim  (count_lim_r),
    .len_lim    (len_lim_r),
    .emit       (emit)
  );

  assign pop = out_valid && out_ready;

  rrsp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (fire ? emit.count : 2'd0),
    .push_data (emit.res),
    .pop       (pop),
    .room      (room),
    .out_valid (out_valid),
    .out_data  (head)
  );

  assign out_event_kind     = head.event_kind;
  assign out_byte_value     = head.byte_value;
  assign out_error_kind     = head.error_kind;
  assign out_argument_total = head.argument_total;
  assign out_last_of_run    = head.last_of_run;

endmodule

[verif/tb_resp_request_stream_parser_top.sv]
// Testbench for the request stream parser: random and directed byte streams, scoreboard check.
`timescale 1ns / 1ps

module tb_resp_request_stream_parser_top;
  import rrsp_pkg::*;

  typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_byte_value;
  logic [2:0]  out_error_kind;
  logic [19:0] out_argument_total;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [24:0] cfg_data = 25'd0;

  resp_request_stream_parser_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte_in(in_byte_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_kind(out_event_kind), .out_byte_value(out_byte_value),
    .out_error_kind(out_error_kind), .out_argument_total(out_argument_total),
    .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pace_t       pace = PACE_FREE;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_planned = 0;
  logic [7:0]  pending_bytes[$];
  logic [7:0]  cmd_bytes[$];
  result_t     expected_events[$];
  result_t     step_events[$];
  result_t     want;

  // parser shadow state and limits
  logic [15:0] line_limit = INLINE_LIMIT_RST;
  logic [19:0] count_limit = COUNT_LIMIT_RST;
  logic [24:0] length_limit = LENGTH_LIMIT_RST;
  phase_t      parse_state = PH_IDLE;
  logic [24:0] acc = '0;
  logic [19:0] args_left = '0;
  logic [24:0] data_left = '0;
  logic [15:0] line_cnt = '0;
  logic        cr_held = 1'b0;
  logic        tok_open = 1'b0;
  logic [19:0] args_done = '0;

  function automatic void clear_parse();
    parse_state = PH_IDLE;
    acc = '0;
    args_left = '0;
    data_left = '0;
    line_cnt = '0;
    cr_held = 1'b0;
    tok_open = 1'b0;
    args_done = '0;
  endfunction

  function automatic void add_event(logic [1:0] kind, logic [7:0] value, logic [2:0] err,
                                    logic [19:0] total);
    result_t r;
    r.event_kind = kind;
    r.byte_value = value;
    r.error_kind = err;
    r.argument_total = total;
    r.last_of_run = 1'b0;
    step_events.insert(step_events.size(), r);
  endfunction

  function automatic void raise_error(logic [2:0] err);
    clear_parse();
    add_event(EV_ERR, 8'd0, err, 20'd0);
  endfunction

  function automatic void close_arg();
    if (tok_open) begin
      tok_open = 1'b0;
      args_done = args_done + 20'd1;
      add_event(EV_AEND, 8'd0, ERR_NONE, 20'd0);
    end
  endfunction

  function automatic void inline_step(logic [7:0] b);
    logic [19:0] total;
    parse_state = PH_INLINE;
    if (b == CH_LF) begin
      cr_held = 1'b0;
      close_arg();
      total = args_done;
      clear_parse();
      add_event(EV_CEND, 8'd0, ERR_NONE, total);
      return;
    end
    if (line_cnt >= line_limit) begin
      raise_error(ERR_INLINE_LEN);
      return;
    end
    line_cnt = line_cnt + 16'd1;
    if (cr_held) begin
      cr_held = 1'b0;
      tok_open = 1'b1;
      add_event(EV_BYTE, CH_CR, ERR_NONE, 20'd0);
    end
    if (b == CH_CR) begin
      cr_held = 1'b1;
    end else if (b == CH_SPACE || b == CH_TAB) begin
      close_arg();
    end else begin
      tok_open = 1'b1;
      add_event(EV_BYTE, b, ERR_NONE, 20'd0);
    end
  endfunction

  function automatic logic [2:0] digit_error(logic [7:0] b, logic [24:0] lim);
    logic [63:0] v;
    if (b < "0" || b > "9") return ERR_BAD_DIGIT;
    v = 64'(acc);
    v = v * 64'd10 + 64'(b - "0");
    if (v > 64'(lim)) return ERR_OVER_LIMIT;
    acc = v[24:0];
    return ERR_NONE;
  endfunction

  // Expected events for one accepted request byte.
  function automatic void parse_byte(logic [7:0] b);
    logic [2:0]  err;
    logic [19:0] total;
    step_events.delete();
    case (parse_state)
      PH_IDLE: begin
        if (b == CH_STAR) begin
          parse_state = PH_COUNT;
          acc = '0;
        end else begin
          inline_step(b);
        end
      end
      PH_INLINE: inline_step(b);
      PH_COUNT, PH_LEN: begin
        if (b == CH_CR) begin
          parse_state = (parse_state == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else begin
          err = digit_error(b, (parse_state == PH_COUNT) ? {5'd0, count_limit} : length_limit);
          if (err != ERR_NONE) raise_error(err);
        end
      end
      PH_COUNT_LF: begin
        if (b != CH_LF) begin
          raise_error(ERR_NO_LF);
        end else if (acc == 0) begin
          raise_error(ERR_ZERO_COUNT);
        end else begin
          args_left = acc[19:0];
          args_done = '0;
          acc = '0;
          parse_state = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (b != CH_DOLLAR) begin
          raise_error(ERR_NO_DOLLAR);
        end else begin
          acc = '0;
          parse_state = PH_LEN;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          raise_error(ERR_NO_LF);
        end else begin
          data_left = acc;
          acc = '0;
          parse_state = (data_left == 0) ? PH_DATA_CR : PH_DATA;
        end
      end
      PH_DATA: begin
        add_event(EV_BYTE, b, ERR_NONE, 20'd0);
        data_left = data_left - 25'd1;
        if (data_left == 0) parse_state = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (b != CH_CR) raise_error(ERR_NO_CRLF);
        else parse_state = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (b != CH_LF) begin
          raise_error(ERR_NO_CRLF);
        end else begin
          args_done = args_done + 20'd1;
          add_event(EV_AEND, 8'd0, ERR_NONE, 20'd0);
          args_left = args_left - 20'd1;
          if (args_left == 0) begin
            total = args_done;
            clear_parse();
            add_event(EV_CEND, 8'd0, ERR_NONE, total);
          end else begin
            parse_state = PH_DOLLAR;
          end
        end
      end
      default: clear_parse();
    endcase
    if (step_events.size() != 0) step_events[step_events.size() - 1].last_of_run = 1'b1;
    foreach (step_events[i]) expected_events.insert(expected_events.size(), step_events[i]);
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit sender_gap();
    return (pace == PACE_SENDER && roll(84)) || (pace == PACE_BOTH && roll(12));
  endfunction

  function automatic bit receiver_stall();
    return (pace == PACE_RECEIVER && roll(84)) || (pace == PACE_BOTH && roll(12));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_byte(in_byte_in);
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && !sender_gap()) begin
          in_valid <= 1'b1;
          in_byte_in <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result item: event_kind %0d", out_event_kind);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 32'(want.event_kind), 32'(out_event_kind));
          check_field("byte_value", 32'(want.byte_value), 32'(out_byte_value));
          check_field("error_kind", 32'(want.error_kind), 32'(out_error_kind));
          check_field("argument_total", 32'(want.argument_total), 32'(out_argument_total));
          check_field("last_of_run", 32'(want.last_of_run), 32'(out_last_of_run));
        end
      end
      out_ready <= !receiver_stall();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus building
  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    cmd_bytes.insert(cmd_bytes.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic add_number(input int unsigned n, input bit pad);
    if (pad) add_byte("0");
    add_text($sformatf("%0d", n));
  endtask

  task automatic flush_cmd();
    bytes_planned += cmd_bytes.size();
    foreach (cmd_bytes[i]) pending_bytes.insert(pending_bytes.size(), cmd_bytes[i]);
    cmd_bytes.delete();
  endtask

  task automatic gen_bulk(input bit corrupt);
    int unsigned nargs;
    int unsigned len;
    int unsigned k;
    nargs = $urandom_range(1, (count_limit == 0) ? 1 : min_u(4, 32'(count_limit)));
    add_byte(CH_STAR);
    add_number(nargs, roll(12));
    add_crlf();
    repeat (nargs) begin
      add_byte(CH_DOLLAR);
      len = $urandom_range(0, min_u(6, 32'(length_limit)));
      if (len != 0 || roll(50)) add_number(len, roll(10));
      add_crlf();
      repeat (len) add_byte(8'($urandom_range(0, 255)));
      add_crlf();
    end
    if (corrupt) begin
      k = $urandom_range(0, cmd_bytes.size() - 1);
      cmd_bytes[k] = 8'($urandom_range(0, 255));
    end
    flush_cmd();
  endtask

  task automatic gen_overflow();
    if (roll(50)) begin
      add_byte(CH_STAR);
      add_number(32'(count_limit) + $urandom_range(1, 99), 1'b0);
    end else begin
      add_byte(CH_STAR);
      add_number(1, 1'b0);
      add_crlf();
      add_byte(CH_DOLLAR);
      add_number(32'(length_limit) + $urandom_range(1, 99), 1'b0);
    end
    add_crlf();
    flush_cmd();
  endtask

  task automatic gen_inline(input bit too_long);
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;
    if (too_long && line_limit <= 40) n = 32'(line_limit) + $urandom_range(1, 3);
    else n = $urandom_range(0, min_u(12, 32'(line_limit)));
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k == 0) b = CH_SPACE;
      else if (k == 1) b = CH_TAB;
      else if (k == 2) b = CH_CR;
      else b = 8'($urandom_range(0, 255));
      if (b == CH_LF || (i == 0 && b == CH_STAR)) b = "s";
      add_byte(b);
    end
    add_byte(CH_LF);
    flush_cmd();
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
    flush_cmd();
  endtask

  task automatic gen_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) gen_bulk(1'b0);
    else if (r < 72) gen_inline(1'b0);
    else if (r < 80) gen_inline(1'b1);
    else if (r < 88) gen_bulk(1'b1);
    else if (r < 94) gen_overflow();
    else gen_noise();
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [24:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INLINE_LIMIT: line_limit = value[15:0];
      CFG_COUNT_LIMIT:  count_limit = value[19:0];
      CFG_LENGTH_LIMIT: length_limit = value;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [24:0] line_v, input logic [24:0] count_v,
                            input logic [24:0] length_v);
    write_limit(CFG_INLINE_LIMIT, line_v);
    write_limit(CFG_COUNT_LIMIT, count_v);
    write_limit(CFG_LENGTH_LIMIT, length_v);
  endtask

  task automatic run_phase(input pace_t p, input int unsigned budget);
    pace = p;
    bytes_planned = 0;
    while (bytes_planned < budget) gen_command();
    settle();
  endtask

  task automatic directed_stream();
    add_text("PING"); add_crlf();
    add_byte(CH_LF);
    add_text(" \t "); add_byte(CH_LF);
    add_text("a"); add_byte(CH_CR); add_text("b c\t*x "); add_crlf();
    add_byte(8'h00); add_byte(8'hFF); add_byte(CH_LF);
    add_text("*2"); add_crlf(); add_text("$3"); add_crlf(); add_text("SET"); add_crlf();
    add_text("$"); add_crlf(); add_crlf();
    add_text("*01"); add_crlf(); add_text("$4"); add_crlf();
    add_byte(8'h00); add_byte(8'hFF); add_byte(CH_CR); add_byte(CH_LF); add_crlf();
    add_text("*1"); add_crlf(); add_text("$0"); add_crlf(); add_crlf();
    add_text("*x");
    add_text("*"); add_byte(CH_LF);
    add_text("*1"); add_byte(CH_CR); add_text("x");
    add_text("*"); add_crlf();
    add_text("*0"); add_crlf();
    add_text("*1"); add_crlf(); add_text("x");
    add_text("*1"); add_crlf(); add_text("$1"); add_crlf(); add_text("ab");
    add_text("*1"); add_crlf(); add_text("$1"); add_crlf(); add_text("a"); add_byte(CH_CR);
    add_text("x");
    add_text("*1"); add_crlf(); add_text("$1x");
    add_text("*1"); add_crlf(); add_text("$1"); add_byte(CH_CR); add_text("y");
    add_text("*9999"); add_crlf();
    add_text("*1"); add_crlf(); add_text("$5000"); add_crlf();
    flush_cmd();
  endtask

  initial begin
    clear_parse();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    pace = PACE_FREE;
    directed_stream();
    settle();
    run_phase(PACE_FREE, 45);

    set_limits(25'd65535, 25'd1048575, 25'd33554431);
    run_phase(PACE_SENDER, 55);

    set_limits(25'd1, 25'd1, 25'd0);
    run_phase(PACE_RECEIVER, 55);

    set_limits(25'd0, 25'd0, 25'd0);
    write_limit(CFG_UNUSED_INDEX, 25'h1FFFFFF);
    run_phase(PACE_BOTH, 20);

    set_limits({9'($urandom_range(0, 511)), 16'($urandom_range(4, 40))},
               25'($urandom_range(1, 6)), 25'($urandom_range(0, 10)));
    run_phase(PACE_BOTH, 55);

    set_limits({9'd0, INLINE_LIMIT_RST}, {5'd0, COUNT_LIMIT_RST}, LENGTH_LIMIT_RST);
    run_phase(PACE_FREE, 55);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rrsp_pkg.sv
rtl/rrsp_core.sv
rtl/rrsp_fifo.sv
rtl/resp_request_stream_parser_top.sv
verif/tb_resp_request_stream_parser_top.sv
